// File: design/pli_pkg.sv
// Shared types and constants for the positional list block.
package pli_pkg;

	// Wide enough for any position or length over the supported depth range.
	localparam int CMP_W = 7;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_PRINT  = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_REJECT   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_ENTRY    = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_PRINT
	} fsm_t;

	typedef struct packed {
		cell_op_t           op;
		logic [CMP_W-1:0]   pos;
		logic [CMP_W-1:0]   len;
		logic [VAL_W-1:0]   value;
	} cell_cmd_t;

endpackage

// File: design/pli_cell.sv
// One list slot: holds an entry, matches it and shifts to or from its neighbors.
module pli_cell import pli_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [VAL_W-1:0] prev_val,   // slot IDX-1
	input  logic [VAL_W-1:0] next_val,   // slot IDX+1
	input  logic [VAL_W-1:0] head_val,   // slot 0, for wrap in rotation
	input  logic             hit_in,     // a match lies below this slot
	output logic             hit_out,
	output logic [VAL_W-1:0] val
);

	localparam logic [CMP_W-1:0] IDX_L  = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] IDX_N1 = CMP_W'(IDX + 1);

	logic [VAL_W-1:0] val_q;
	logic             hit;

	assign hit     = hit_in || ((IDX_L < cmd.len) && (val_q == cmd.value));
	assign hit_out = hit;
	assign val     = val_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INS: begin
				if (IDX_L == cmd.pos)
					val_q <= cmd.value;
				else if ((IDX_L > cmd.pos) && (IDX_L <= cmd.len))
					val_q <= prev_val;
			end
			CELL_DEL: begin
				if (hit && (IDX_N1 < cmd.len))
					val_q <= next_val;
			end
			CELL_ROT: begin
				if (IDX_N1 < cmd.len)
					val_q <= next_val;
				else if (IDX_N1 == cmd.len)
					val_q <= head_val;
			end
			default: ;
		endcase
	end

endmodule

// File: design/positional_list_insert_remove.sv
// Top level: ordered list of signed words with insert, remove, print and clear.
// Insert, remove and clear: result registered the cycle after accept; one request per
// cycle while the result side keeps up, since every slot shifts at once.
// Print: accept enters the print state, which loads one entry per cycle into the
// result register while the result side keeps up; the row rotates one place per entry.
// Reset clears the length, the print sequencer and the result valid; slot contents
// keep no reset and are only read below the length.
module positional_list_insert_remove import pli_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] item_value, [37:32] position, [39:38] zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] entry_value, [37:32] list_length, [39:38] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	localparam int LW = $clog2(DEPTH + 1);

	// request fields
	func_t            func;
	logic [VAL_W-1:0] item_value;
	logic [POS_W-1:0] position;

	assign func       = func_t'(s_tuser);
	assign item_value = s_tdata[31:0];
	assign position   = s_tdata[37:32];

	// control state
	fsm_t             state_q, state_d;
	logic [LW-1:0]    len_q, len_d;
	logic [LW-1:0]    cnt_q, cnt_d;

	// result register
	logic             m_valid_q;
	status_t          status_q;
	logic [VAL_W-1:0] entry_q;
	logic [POS_W-1:0] olen_q;
	logic             last_q;

	logic             take, load_ok, ins_ok, found;
	logic             out_load, out_last;
	status_t          out_status;
	logic [VAL_W-1:0] out_entry;
	cell_cmd_t        cmd;

	// slot row wiring
	logic [VAL_W-1:0] slot_val [DEPTH];
	logic             hit_chain [DEPTH+1];

	assign load_ok  = !m_valid_q || m_tready;
	assign s_tready = (state_q == FSM_IDLE) && load_ok;
	assign take     = s_tvalid && s_tready;

	// insert fits if position is within the list and there is a free slot
	assign ins_ok = ({1'b0, position} <= CMP_W'(len_q)) && (len_q < LW'(DEPTH));
	assign found  = hit_chain[DEPTH];

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		pli_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.prev_val (slot_val[(i == 0) ? 0 : i - 1]),
			.next_val (slot_val[(i == DEPTH - 1) ? i : i + 1]),
			.head_val (slot_val[0]),
			.hit_in   (hit_chain[i]),
			.hit_out  (hit_chain[i+1]),
			.val      (slot_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		out_load   = 1'b0;
		out_status = ST_DONE;
		out_entry  = '0;
		out_last   = 1'b1;
		cmd.op     = CELL_HOLD;
		cmd.pos    = CMP_W'(position);
		cmd.len    = CMP_W'(len_q);
		cmd.value  = item_value;
		unique case (state_q)
			FSM_IDLE: begin
				if (take) begin
					out_load = 1'b1;
					unique case (func)
						FN_INSERT: begin
							if (ins_ok) begin
								cmd.op = CELL_INS;
								len_d  = len_q + LW'(1);
							end else
								out_status = ST_REJECT;
						end
						FN_REMOVE: begin
							if (found) begin
								cmd.op = CELL_DEL;
								len_d  = len_q - LW'(1);
							end else
								out_status = ST_NOTFOUND;
						end
						FN_PRINT: begin
							if (len_q == '0)
								out_status = ST_EMPTY;
							else begin
								// entries go out from the print state
								out_load = 1'b0;
								state_d  = FSM_PRINT;
								cnt_d    = '0;
							end
						end
						FN_CLEAR: len_d = '0;
						default: ;
					endcase
				end
			end
			FSM_PRINT: begin
				if (load_ok) begin
					out_load   = 1'b1;
					out_status = ST_ENTRY;
					out_entry  = slot_val[0];
					out_last   = ((cnt_q + LW'(1)) == len_q);
					cmd.op     = CELL_ROT;
					cnt_d      = cnt_q + LW'(1);
					if (out_last)
						state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status;
			entry_q  <= out_entry;
			olen_q   <= POS_W'(len_d);
			last_q   <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, olen_q, entry_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	// length never runs past the slot count
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(DEPTH))
		else $error("list length beyond depth");

	// no new request while a print run is going out
	a_print_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_PRINT) |-> !s_tready)
		else $error("request taken during print");

	// every accepted request shows a result the next cycle or starts a print run
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (m_tvalid || state_q == FSM_PRINT))
		else $error("accepted request gave no result");

	// only a print run leaves a non-final result pending
	a_nonlast_print: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (state_q == FSM_PRINT && m_tuser == ST_ENTRY))
		else $error("non-final result outside print");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the positional list block: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
	import pli_pkg::*;

	localparam int DEPTH = 32;
	// Worst case is far below this: 32-entry prints under random result stalls and one long hold-off.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_REQUESTS = 450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [31:0] item_value, [37:32] position, [39:38] zero
	logic [1:0]  s_tuser = '0;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] entry_value, [37:32] list_length, [39:38] zero
	logic [2:0]  m_tuser;        // [2:0] status
	logic        m_tlast;

	// One result item as the list should produce it.
	typedef struct {
		status_t     status;
		logic [31:0] value;
		logic [5:0]  length;
		logic        last;
	} list_result_t;

	// Shadow copy of the list; every accepted request is applied here and its
	// results are queued for comparison in arrival order.
	class list_scoreboard;
		logic [31:0]  slots [DEPTH];
		int unsigned  len;
		list_result_t awaited [$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  full_rejects;
		int unsigned  max_len;
		int unsigned  req_count [4];

		function new();
			len = 0;
			errors = 0;
			checked = 0;
			full_rejects = 0;
			max_len = 0;
			foreach (req_count[k]) req_count[k] = 0;
		endfunction

		function void queue_result(status_t st, logic [31:0] val, logic is_last);
			list_result_t r;
			r.status = st;
			r.value  = val;
			r.length = len[5:0];
			r.last   = is_last;
			awaited.push_back(r);
		endfunction

		function void note_request(func_t fn, logic [31:0] val, logic [5:0] pos);
			int unsigned i;
			req_count[fn]++;
			case (fn)
				FN_INSERT: begin
					if (pos > len || len >= DEPTH) begin
						if (len >= DEPTH) full_rejects++;
						queue_result(ST_REJECT, '0, 1'b1);
					end else begin
						for (i = len; i > pos; i--) slots[i] = slots[i-1];
						slots[pos] = val;
						len++;
						queue_result(ST_DONE, '0, 1'b1);
					end
				end
				FN_REMOVE: begin
					// first match wins, later entries slide down
					i = 0;
					while (i < len && slots[i] !== val) i++;
					if (i == len) begin
						queue_result(ST_NOTFOUND, '0, 1'b1);
					end else begin
						for (; i + 1 < len; i++) slots[i] = slots[i+1];
						len--;
						queue_result(ST_DONE, '0, 1'b1);
					end
				end
				FN_PRINT: begin
					if (len == 0) begin
						queue_result(ST_EMPTY, '0, 1'b1);
					end else begin
						for (i = 0; i < len; i++) queue_result(ST_ENTRY, slots[i], i + 1 == len);
					end
				end
				default: begin
					// clear drops the length only; stale slots are never read again
					len = 0;
					queue_result(ST_DONE, '0, 1'b1);
				end
			endcase
			if (len > max_len) max_len = len;
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] val, logic [5:0] n, logic is_last);
			list_result_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual status %0d value %h length %0d last %b",
					$time, st, val, n, is_last);
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (st !== e.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
			end
			if (val !== e.value) begin
				errors++;
				$display("%0t: entry_value mismatch: expected %h actual %h", $time, e.value, val);
			end
			if (n !== e.length) begin
				errors++;
				$display("%0t: list_length mismatch: expected %0d actual %0d", $time, e.length, n);
			end
			if (is_last !== e.last) begin
				errors++;
				$display("%0t: last mismatch: expected %b actual %b", $time, e.last, is_last);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	list_scoreboard sb = new();

	// Idle knobs, one for each side; calm turns idling off for the final stretch.
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	bit          calm = 1'b0;
	int unsigned cycles = 0;

	positional_list_insert_remove #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still awaited", $time, cycles,
				sb.pending());
			$display("positional_list_insert_remove test failed");
			$finish;
		end
	end

	// Result side: every accepted result is compared against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast);
	end

	// Result-side flow control: random stall bursts, plus one long hold-off that
	// lets the block back up and stall its request side.
	initial begin
		bit held;
		held = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && sb.checked >= 80) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < snk_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Hold one request on the bus until it is taken, then apply it to the shadow list.
	// tvalid is left high; the caller drops it only when a gap follows.
	task automatic offer_request(func_t fn, logic [31:0] val, logic [5:0] pos);
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, pos, val};
		do @(posedge clk); while (!s_tready);
		sb.note_request(fn, val, pos);
	endtask

	// Values lean on extremes and a narrow band so duplicates and matches are common.
	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 11);
		case (r)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4, 5, 6: return 32'($signed($urandom_range(0, 6)) - 3);
			7, 8: return (sb.len > 0) ? sb.slots[$urandom_range(0, sb.len - 1)] : $urandom;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned n;
		int unsigned r;
		int unsigned phase;
		int unsigned w_ins, w_bad, w_rem, w_miss, w_prt;
		int unsigned idle_pick [3];
		func_t       fn;
		logic [31:0] val;
		logic [5:0]  pos;

		idle_pick[0] = 0;
		idle_pick[1] = 10;
		idle_pick[2] = 40;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list cases, extremes, first-match remove, stale slots.
		offer_request(FN_PRINT,  32'h0, 6'd0);          // empty print
		offer_request(FN_REMOVE, 32'h0, 6'd0);          // remove from empty list
		offer_request(FN_INSERT, 32'h1, 6'd1);          // position past length
		offer_request(FN_INSERT, 32'hffff_ffff, 6'd63); // all position bits set
		offer_request(FN_INSERT, 32'h7fff_ffff, 6'd0);
		offer_request(FN_INSERT, 32'h8000_0000, 6'd0);  // insert at front
		offer_request(FN_INSERT, 32'hffff_ffff, 6'd2);  // append at tail
		offer_request(FN_INSERT, 32'h0, 6'd1);          // middle
		offer_request(FN_INSERT, 32'hffff_ffff, 6'd1);  // duplicate of the tail value
		offer_request(FN_INSERT, 32'h5, 6'd6);          // one past length
		offer_request(FN_PRINT,  32'h0, 6'd0);
		offer_request(FN_REMOVE, 32'hffff_ffff, 6'd0);  // must take the first copy
		offer_request(FN_REMOVE, 32'd12345, 6'd0);      // no match
		offer_request(FN_REMOVE, 32'h8000_0000, 6'd0);  // head
		offer_request(FN_REMOVE, 32'hffff_ffff, 6'd0);  // tail
		offer_request(FN_PRINT,  32'h0, 6'd0);
		offer_request(FN_CLEAR,  32'hffff_ffff, 6'd63);
		offer_request(FN_PRINT,  32'h0, 6'd0);
		offer_request(FN_REMOVE, 32'h0, 6'd0);          // old bits must not match after clear
		offer_request(FN_INSERT, 32'd42, 6'd0);
		offer_request(FN_PRINT,  32'h0, 6'd0);

		// Random part: phases that fill, churn and drain the list.
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 50 == 0) begin
				src_idle_pct = idle_pick[$urandom_range(0, 2)];
				snk_idle_pct = idle_pick[$urandom_range(0, 2)];
			end
			if (n >= RANDOM_REQUESTS - 50) calm = 1'b1;
			phase = (n / 60) % 3;
			case (phase)
				0: begin w_ins = 70; w_bad = 75; w_rem = 85; w_miss = 88; w_prt = 100; end
				1: begin w_ins = 40; w_bad = 47; w_rem = 72; w_miss = 80; w_prt = 95; end
				default: begin w_ins = 20; w_bad = 25; w_rem = 75; w_miss = 83; w_prt = 95; end
			endcase

			r = $urandom_range(0, 99);
			val = pick_value();
			pos = 6'($urandom_range(0, sb.len));
			if (r < w_ins) begin
				fn = FN_INSERT;
			end else if (r < w_bad) begin
				fn = FN_INSERT;
				pos = 6'($urandom_range(sb.len + 1, 63));
			end else if (r < w_rem) begin
				fn = FN_REMOVE;
				if (sb.len > 0) val = sb.slots[$urandom_range(0, sb.len - 1)];
			end else if (r < w_miss) begin
				fn = FN_REMOVE;
				val = $urandom;
			end else if (r < w_prt) begin
				fn = FN_PRINT;
				pos = 6'($urandom);
			end else begin
				fn = FN_CLEAR;
				pos = 6'($urandom);
			end

			if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			offer_request(fn, val, pos);
		end
		s_tvalid <= 1'b0;

		// Drain, then allow a print's worth of cycles for any stray result.
		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);

		$display("Ran %0d inserts, %0d removes, %0d prints and %0d clears; %0d results compared.",
			sb.req_count[FN_INSERT], sb.req_count[FN_REMOVE], sb.req_count[FN_PRINT],
			sb.req_count[FN_CLEAR], sb.checked);
		$display("List reached %0d entries; %0d inserts were turned away by a full list.",
			sb.max_len, sb.full_rejects);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("positional_list_insert_remove test passed");
		end else begin
			$display("positional_list_insert_remove test failed");
		end
		$finish;
	end

endmodule
